// ===== rtl/htce_pkg.sv =====
package htce_pkg;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam int NAME_BYTES = 8;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAG_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAG_CHARS  = 2'd1;

   localparam logic [3:0]  TAG_LENGTH_RESET = 4'd7;
   localparam logic [63:0] TAG_CHARS_RESET  = 64'h0065_6C63_6974_7261;

   localparam int QUEUE_DEPTH = 4;

   localparam logic KIND_CONTENT = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef struct packed {
      logic [7:0] doc_byte;
      logic       doc_end;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] content_byte;
      logic       found;
      logic       final_res;
   } rsp_type;

   typedef struct packed {
      logic       has_byte;
      logic       is_end;
      logic [7:0] data;
   } token_type;

   typedef enum logic [1:0] {
      FP_SEEK,
      FP_SKIP,
      FP_BODY
   } front_phase_type;

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

   function automatic logic is_delim(input logic [7:0] b);
      return (b == CH_GT) || (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
             (b == CH_SLASH);
   endfunction

   function automatic logic [7:0] name_char(input logic [63:0] chars, input int k);
      logic [7:0] r;
      r = 8'h00;
      if (k >= 0 && k < NAME_BYTES) begin
         r = chars[8*k +: 8];
      end
      return r;
   endfunction

endpackage

// ===== rtl/htce_scan.sv =====
module htce_scan #(
   parameter int MAX_TAG = 8,
   parameter int PL      = 1,
   localparam int DEPTH  = PL + MAX_TAG + 1,
   localparam int CW     = $clog2(DEPTH + 1),
   localparam int LW     = $clog2(MAX_TAG + 1)
) (
   input  logic [7:0]    win [DEPTH],
   input  logic [CW-1:0] n,
   input  logic [LW-1:0] len,
   input  logic [63:0]   chars,
   output logic [CW-1:0] start,
   output logic          full
);
   import htce_pkg::*;

   logic [DEPTH-1:0] ok;

   function automatic logic pos_ok(input logic [7:0] b, input int k, input int nlen,
                                   input logic [63:0] ch);
      logic r;
      r = 1'b0;
      if (k == 0) begin
         r = (b == CH_LT);
      end else if (PL == 2 && k == 1) begin
         r = (b == CH_SLASH);
      end else if (k < PL + nlen) begin
         r = (to_lower(b) == name_char(ch, k - PL));
      end else if (k == PL + nlen) begin
         r = is_delim(b);
      end
      return r;
   endfunction

   always_comb begin
      for (int s = 0; s < DEPTH; s++) begin
         ok[s] = (s < int'(n));
         for (int j = s; j < DEPTH; j++) begin
            if (j < int'(n) && !pos_ok(win[j], j - s, int'(len), chars)) begin
               ok[s] = 1'b0;
            end
         end
      end
      start = n;
      for (int s = DEPTH - 1; s >= 0; s--) begin
         if (ok[s]) begin
            start = CW'(s);
         end
      end
      full = ((int'(n) - int'(start)) == (PL + int'(len) + 1));
   end

endmodule

// ===== rtl/htce_front.sv =====
module htce_front #(
   parameter int MAX_TAG = 8,
   localparam int LW     = $clog2(MAX_TAG + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  htce_pkg::req_type     req_data,
   input  logic [LW-1:0]         len,
   input  logic [63:0]           chars,
   input  logic                  q_full,
   output logic                  push,
   output htce_pkg::token_type   push_token
);
   import htce_pkg::*;

   localparam int FD = MAX_TAG + 2;
   localparam int FH = MAX_TAG + 1;
   localparam int RC = MAX_TAG;
   localparam int CW = $clog2(FD + 1);
   localparam int RW = $clog2(RC + 1);

   front_phase_type phase_ff, phase_in;
   logic [7:0]      held_ff [FH];
   logic [7:0]      held_in [FH];
   logic [CW-1:0]   held_cnt_ff, held_cnt_in;
   logic [7:0]      rep_ff [RC];
   logic [7:0]      rep_in [RC];
   logic [RW-1:0]   rep_cnt_ff, rep_cnt_in;
   logic            rep_end_ff, rep_end_in;

   logic [7:0]      tmp [FD];
   logic [CW-1:0]   n;
   logic [CW-1:0]   sc_start;
   logic            sc_full;
   logic            gt_found;
   logic [CW-1:0]   gt_pos;
   logic [CW-1:0]   trail_start;
   logic [CW-1:0]   trail_cnt;
   logic [7:0]      trail_first;
   logic [7:0]      trail_rest [RC];
   logic [7:0]      held_shift [FH];
   logic            accept;

   always_comb begin
      for (int j = 0; j < FH; j++) begin
         tmp[j] = (CW'(j) < held_cnt_ff) ? held_ff[j] : req_data.doc_byte;
      end
      tmp[FD-1] = req_data.doc_byte;
   end

   assign n = held_cnt_ff + CW'(1);

   htce_scan #(
      .MAX_TAG (MAX_TAG),
      .PL      (1)
   ) u_scan (
      .win   (tmp),
      .n     (n),
      .len   (len),
      .chars (chars),
      .start (sc_start),
      .full  (sc_full)
   );

   always_comb begin
      gt_found = 1'b0;
      gt_pos   = '0;
      for (int j = FD - 1; j >= 0; j--) begin
         if (CW'(j) >= sc_start && CW'(j) < n && tmp[j] == CH_GT) begin
            gt_found = 1'b1;
            gt_pos   = CW'(j);
         end
      end
      trail_start = gt_pos + CW'(1);
      trail_cnt   = gt_found ? (n - trail_start) : '0;
      trail_first = 8'h00;
      for (int j = 0; j < FD; j++) begin
         if (CW'(j) == trail_start) begin
            trail_first = tmp[j];
         end
      end
      for (int i = 0; i < RC; i++) begin
         trail_rest[i] = 8'h00;
         for (int j = 0; j < FD; j++) begin
            if (j == int'(trail_start) + 1 + i) begin
               trail_rest[i] = tmp[j];
            end
         end
      end
      for (int i = 0; i < FH; i++) begin
         held_shift[i] = 8'h00;
         for (int j = 0; j < FD; j++) begin
            if (j == int'(sc_start) + i) begin
               held_shift[i] = tmp[j];
            end
         end
      end
   end

   assign req_stall = (rep_cnt_ff != '0) || q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      rep_in      = rep_ff;
      rep_cnt_in  = rep_cnt_ff;
      rep_end_in  = rep_end_ff;
      push        = 1'b0;
      push_token  = '0;
      if (rep_cnt_ff != '0) begin
         if (!q_full) begin
            push                = 1'b1;
            push_token.has_byte = 1'b1;
            push_token.is_end   = rep_end_ff && (rep_cnt_ff == RW'(1));
            push_token.data     = rep_ff[0];
            for (int i = 0; i < RC - 1; i++) begin
               rep_in[i] = rep_ff[i+1];
            end
            rep_cnt_in = rep_cnt_ff - RW'(1);
         end
      end else if (accept) begin
         case (phase_ff)
            FP_SEEK: begin
               if (sc_full) begin
                  held_cnt_in = '0;
                  phase_in    = gt_found ? FP_BODY : FP_SKIP;
                  if (trail_cnt != '0) begin
                     push                = 1'b1;
                     push_token.has_byte = 1'b1;
                     push_token.is_end   = req_data.doc_end && (trail_cnt == CW'(1));
                     push_token.data     = trail_first;
                     rep_in              = trail_rest;
                     rep_cnt_in          = RW'(trail_cnt - CW'(1));
                     rep_end_in          = req_data.doc_end;
                  end else if (req_data.doc_end) begin
                     push              = 1'b1;
                     push_token.is_end = 1'b1;
                  end
               end else begin
                  held_in     = held_shift;
                  held_cnt_in = n - sc_start;
                  if (req_data.doc_end) begin
                     held_cnt_in       = '0;
                     push              = 1'b1;
                     push_token.is_end = 1'b1;
                  end
               end
               if (req_data.doc_end) begin
                  phase_in = FP_SEEK;
               end
            end
            FP_SKIP: begin
               if (req_data.doc_byte == CH_GT) begin
                  phase_in = FP_BODY;
               end
               if (req_data.doc_end) begin
                  push              = 1'b1;
                  push_token.is_end = 1'b1;
                  phase_in          = FP_SEEK;
               end
            end
            FP_BODY: begin
               push                = 1'b1;
               push_token.has_byte = 1'b1;
               push_token.is_end   = req_data.doc_end;
               push_token.data     = req_data.doc_byte;
               if (req_data.doc_end) begin
                  phase_in = FP_SEEK;
               end
            end
            default: begin
               phase_in = FP_SEEK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= FP_SEEK;
         held_cnt_ff <= '0;
         rep_cnt_ff  <= '0;
         rep_end_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         held_cnt_ff <= held_cnt_in;
         rep_cnt_ff  <= rep_cnt_in;
         rep_end_ff  <= rep_end_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      rep_ff  <= rep_in;
   end

   ap_held_only_seek: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != FP_SEEK) |-> (held_cnt_ff == '0))
      else $error("Front holds bytes outside the opening tag search.");

endmodule

// ===== rtl/htce_queue.sv =====
module htce_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  htce_pkg::token_type push_token,
   output logic                full,
   input  logic                pop,
   output htce_pkg::token_type pop_token,
   output logic                empty
);
   import htce_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   token_type     mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;

   assign full      = (count_ff == NW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_token = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

// ===== rtl/htce_back.sv =====
module htce_back #(
   parameter int MAX_TAG = 8,
   localparam int LW     = $clog2(MAX_TAG + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  htce_pkg::token_type tok,
   input  logic                q_empty,
   output logic                pop,
   input  logic [LW-1:0]       len,
   input  logic [63:0]         chars,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output htce_pkg::rsp_type   rsp_data
);
   import htce_pkg::*;

   localparam int TB = MAX_TAG + 3;
   localparam int HB = MAX_TAG + 2;
   localparam int RB = MAX_TAG + 2;
   localparam int CW = $clog2(TB + 1);
   localparam int RW = $clog2(RB + 1);

   logic [7:0]    held_ff [HB];
   logic [7:0]    held_in [HB];
   logic [CW-1:0] held_cnt_ff, held_cnt_in;
   logic          done_ff, done_in;
   logic [7:0]    rel_ff [RB];
   logic [7:0]    rel_in [RB];
   logic [RW-1:0] rel_cnt_ff, rel_cnt_in;
   logic          stat_pend_ff, stat_pend_in;
   logic          stat_found_ff, stat_found_in;
   rsp_type       out_ff, out_in;
   logic          out_valid_ff, out_valid_in;

   logic [7:0]    tmp [TB];
   logic [CW-1:0] n;
   logic [CW-1:0] sc_start;
   logic          sc_full;
   logic [7:0]    held_shift [HB];
   logic          out_free;
   logic          use_byte;
   logic          found_now;
   logic [CW-1:0] rel_len;

   function automatic rsp_type content_item(input logic [7:0] b);
      rsp_type r;
      r.kind         = KIND_CONTENT;
      r.content_byte = b;
      r.found        = 1'b0;
      r.final_res    = 1'b0;
      return r;
   endfunction

   function automatic rsp_type status_item(input logic f);
      rsp_type r;
      r.kind         = KIND_STATUS;
      r.content_byte = 8'h00;
      r.found        = f;
      r.final_res    = 1'b1;
      return r;
   endfunction

   always_comb begin
      for (int j = 0; j < HB; j++) begin
         tmp[j] = (CW'(j) < held_cnt_ff) ? held_ff[j] : tok.data;
      end
      tmp[TB-1] = tok.data;
   end

   assign n = held_cnt_ff + CW'(1);

   htce_scan #(
      .MAX_TAG (MAX_TAG),
      .PL      (2)
   ) u_scan (
      .win   (tmp),
      .n     (n),
      .len   (len),
      .chars (chars),
      .start (sc_start),
      .full  (sc_full)
   );

   always_comb begin
      for (int i = 0; i < HB; i++) begin
         held_shift[i] = 8'h00;
         for (int j = 0; j < TB; j++) begin
            if (j == int'(sc_start) + i) begin
               held_shift[i] = tmp[j];
            end
         end
      end
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign pop       = !q_empty && out_free && (rel_cnt_ff == '0) && !stat_pend_ff;
   assign use_byte  = tok.has_byte && !done_ff;
   assign found_now = done_ff || (use_byte && sc_full);

   always_comb begin
      held_in       = held_ff;
      held_cnt_in   = held_cnt_ff;
      done_in       = done_ff;
      rel_in        = rel_ff;
      rel_cnt_in    = rel_cnt_ff;
      stat_pend_in  = stat_pend_ff;
      stat_found_in = stat_found_ff;
      out_in        = out_ff;
      out_valid_in  = !out_free;
      rel_len       = '0;
      if (rel_cnt_ff != '0) begin
         if (out_free) begin
            out_in       = content_item(rel_ff[0]);
            out_valid_in = 1'b1;
            for (int i = 0; i < RB - 1; i++) begin
               rel_in[i] = rel_ff[i+1];
            end
            rel_cnt_in = rel_cnt_ff - RW'(1);
         end
      end else if (stat_pend_ff) begin
         if (out_free) begin
            out_in       = status_item(stat_found_ff);
            out_valid_in = 1'b1;
            stat_pend_in = 1'b0;
         end
      end else if (pop) begin
         if (use_byte) begin
            if (sc_full) begin
               rel_len     = sc_start;
               done_in     = 1'b1;
               held_cnt_in = '0;
            end else if (tok.is_end) begin
               rel_len = n;
            end else begin
               rel_len     = sc_start;
               held_in     = held_shift;
               held_cnt_in = n - sc_start;
            end
         end else begin
            rel_len = tok.is_end ? held_cnt_ff : '0;
         end
         if (tok.is_end) begin
            held_cnt_in = '0;
            done_in     = 1'b0;
         end
         if (rel_len != '0) begin
            out_in       = content_item(tmp[0]);
            out_valid_in = 1'b1;
            for (int i = 0; i < RB; i++) begin
               rel_in[i] = tmp[i+1];
            end
            rel_cnt_in    = RW'(rel_len - CW'(1));
            stat_pend_in  = tok.is_end;
            stat_found_in = found_now;
         end else if (tok.is_end) begin
            out_in       = status_item(found_now);
            out_valid_in = 1'b1;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff  <= '0;
         done_ff      <= 1'b0;
         rel_cnt_ff   <= '0;
         stat_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         held_cnt_ff  <= held_cnt_in;
         done_ff      <= done_in;
         rel_cnt_ff   <= rel_cnt_in;
         stat_pend_ff <= stat_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff       <= held_in;
      rel_ff        <= rel_in;
      stat_found_ff <= stat_found_in;
      out_ff        <= out_in;
   end

   ap_release_has_output: assert property (@(posedge clock) disable iff (reset)
      (rel_cnt_ff != '0) |-> out_valid_ff)
      else $error("Released bytes pending without a result in the output register.");

   ap_status_has_output: assert property (@(posedge clock) disable iff (reset)
      stat_pend_ff |-> out_valid_ff)
      else $error("Status pending without a result in the output register.");

   ap_done_no_held: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (held_cnt_ff == '0))
      else $error("Bytes held after the closing tag was found.");

   ap_release_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && (rel_cnt_ff != '0)) |=>
      (rel_cnt_ff == $past(rel_cnt_ff)))
      else $error("Release count moved while the output was stalled.");

endmodule

// ===== rtl/html_tag_content_extractor.sv =====
// Streams a document one byte per transfer and returns the content of the first element
// whose opening tag name matches tag_name (case-insensitive), then one status result at the
// byte marked doc_end. In steady state one byte is taken per cycle. The back end emits one
// result per cycle through its output register unless stalled, so a byte that breaks a
// partial closing-tag match releases the held bytes, and the status result follows any bytes
// still held at document end. A four-entry token queue between the tag search and the output
// side absorbs these bursts; when it fills, req_stall rises. An opening tag whose name itself
// contains '>' replays the tag bytes after it into the queue, one per cycle unless full,
// with req_stall high. Configuration takes effect at once and must be written while idle.
module html_tag_content_extractor #(
   parameter int MAX_TAG = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  htce_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output htce_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [htce_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [63:0]                            csr_data
);
   import htce_pkg::*;

   localparam int LW = $clog2(MAX_TAG + 1);

   logic [3:0]    tag_length_ff, tag_length_in;
   logic [63:0]   tag_chars_ff, tag_chars_in;
   logic [LW-1:0] len_eff;
   logic          q_push;
   token_type     q_push_token;
   logic          q_full;
   logic          q_pop;
   token_type     q_pop_token;
   logic          q_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      tag_length_in = tag_length_ff;
      tag_chars_in  = tag_chars_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TAG_LENGTH: tag_length_in = csr_data[3:0];
            CSR_TAG_CHARS:  tag_chars_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_length_ff <= TAG_LENGTH_RESET;
         tag_chars_ff  <= TAG_CHARS_RESET;
      end else begin
         tag_length_ff <= tag_length_in;
         tag_chars_ff  <= tag_chars_in;
      end
   end

   assign len_eff = (int'(tag_length_ff) > MAX_TAG) ? LW'(MAX_TAG) : LW'(tag_length_ff);

   htce_front #(
      .MAX_TAG (MAX_TAG)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .len        (len_eff),
      .chars      (tag_chars_ff),
      .q_full     (q_full),
      .push       (q_push),
      .push_token (q_push_token)
   );

   htce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (q_push_token),
      .full       (q_full),
      .pop        (q_pop),
      .pop_token  (q_pop_token),
      .empty      (q_empty)
   );

   htce_back #(
      .MAX_TAG (MAX_TAG)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok       (q_pop_token),
      .q_empty   (q_empty),
      .pop       (q_pop),
      .len       (len_eff),
      .chars     (tag_chars_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/html_tag_content_extractor_test.sv =====
module html_tag_content_extractor_test;
   import htce_pkg::*;

   localparam int NAME_LIMIT = 8;
   localparam int HOLD_SLOTS = 12;
   localparam int PHASE_ITEMS = 33;
   localparam int DRAIN_CYCLES = 24;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int LONG_HOLD = 300;
   localparam int HOLD_AFTER = 100;

   typedef enum logic [1:0] {
      SEEK_OPEN,
      SKIP_ATTRS,
      IN_BODY,
      PAST_CLOSE
   } doc_stage_type;

   class content_scoreboard;
      logic [3:0] tag_len = TAG_LENGTH_RESET;
      logic [63:0] tag_name = TAG_CHARS_RESET;
      doc_stage_type stage = SEEK_OPEN;
      logic [7:0] held [HOLD_SLOTS];
      int held_n = 0;
      rsp_type pending [$];
      int errors = 0;
      int requests_seen = 0;

      function void configure(logic [CSR_INDEX_WIDTH-1:0] idx, logic [63:0] value);
         if (idx == CSR_TAG_LENGTH) begin
            tag_len = value[3:0];
         end else if (idx == CSR_TAG_CHARS) begin
            tag_name = value;
         end
      endfunction

      function int name_len();
         return (tag_len > NAME_LIMIT) ? NAME_LIMIT : int'(tag_len);
      endfunction

      function logic [7:0] name_at(int k);
         if (k >= NAME_BYTES) begin
            return 8'h00;
         end
         return tag_name[8*k +: 8];
      endfunction

      function logic [7:0] fold(logic [7:0] c);
         return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
      endfunction

      function bit ends_name(logic [7:0] c);
         return c == CH_GT || c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_SLASH;
      endfunction

      // True when w[s..s+m) agrees with the start of the opening or closing pattern.
      function bit agrees(logic [7:0] w [HOLD_SLOTS], int s, int m, bit closing);
         int lead;
         int j;
         logic [7:0] c;
         lead = closing ? 2 : 1;
         for (j = 0; j < m; j++) begin
            c = w[s + j];
            if (j == 0) begin
               if (c != CH_LT) return 0;
            end else if (j == 1 && closing) begin
               if (c != CH_SLASH) return 0;
            end else if (j < lead + name_len()) begin
               if (fold(c) != name_at(j - lead)) return 0;
            end else if (!ends_name(c)) begin
               return 0;
            end
         end
         return 1;
      endfunction

      function int first_start(logic [7:0] w [HOLD_SLOTS], int n, bit closing,
                               output bit full);
         int total;
         int s;
         total = (closing ? 2 : 1) + name_len() + 1;
         for (s = 0; s < n; s++) begin
            if (n - s <= total && agrees(w, s, n - s, closing)) break;
         end
         full = (n - s == total);
         return s;
      endfunction

      function void emit(logic k, logic [7:0] b, logic f, logic e);
         rsp_type r;
         r.kind = k;
         r.content_byte = b;
         r.found = f;
         r.final_res = e;
         pending.push_back(r);
      endfunction

      function void body_byte(logic [7:0] b);
         logic [7:0] w [HOLD_SLOTS];
         int n;
         int s;
         int i;
         bit full;
         for (i = 0; i < held_n; i++) w[i] = held[i];
         w[held_n] = b;
         n = held_n + 1;
         s = first_start(w, n, 1'b1, full);
         for (i = 0; i < s; i++) emit(KIND_CONTENT, w[i], 1'b0, 1'b0);
         if (full) begin
            stage = PAST_CLOSE;
            held_n = 0;
         end else begin
            for (i = s; i < n; i++) held[i - s] = w[i];
            held_n = n - s;
         end
      endfunction

      function void seek_byte(logic [7:0] b);
         logic [7:0] w [HOLD_SLOTS];
         int n;
         int s;
         int i;
         bit full;
         for (i = 0; i < held_n; i++) w[i] = held[i];
         w[held_n] = b;
         n = held_n + 1;
         s = first_start(w, n, 1'b0, full);
         if (!full) begin
            for (i = s; i < n; i++) held[i - s] = w[i];
            held_n = n - s;
            return;
         end
         held_n = 0;
         stage = SKIP_ATTRS;
         // A '>' inside the matched name starts the content right there.
         for (i = s; i < n; i++) begin
            if (stage == SKIP_ATTRS) begin
               if (w[i] == CH_GT) stage = IN_BODY;
            end else if (stage == IN_BODY) begin
               body_byte(w[i]);
            end
         end
      endfunction

      function void note_request(req_type item);
         int i;
         requests_seen++;
         case (stage)
            SEEK_OPEN: seek_byte(item.doc_byte);
            SKIP_ATTRS: if (item.doc_byte == CH_GT) stage = IN_BODY;
            IN_BODY: body_byte(item.doc_byte);
            default: ;
         endcase
         if (item.doc_end) begin
            if (stage == IN_BODY) begin
               for (i = 0; i < held_n; i++) emit(KIND_CONTENT, held[i], 1'b0, 1'b0);
            end
            emit(KIND_STATUS, 8'h00, stage == PAST_CLOSE, 1'b1);
            stage = SEEK_OPEN;
            held_n = 0;
         end
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %b, expected %b", got.kind, want.kind));
         if (got.content_byte !== want.content_byte)
            report($sformatf("content_byte %h, expected %h", got.content_byte,
                             want.content_byte));
         if (got.found !== want.found)
            report($sformatf("found %b, expected %b", got.found, want.found));
         if (got.final_res !== want.final_res)
            report($sformatf("final_res %b, expected %b", got.final_res, want.final_res));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_TAG_LENGTH;
   logic [63:0] csr_data = '0;

   content_scoreboard sb = new;
   logic [7:0] doc_bytes [$];
   bit send_calm = 1'b0;
   int cycle_count = 0;

   html_tag_content_extractor dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [7:0] vary_case(logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] name_byte(int k);
      return vary_case(sb.tag_name[8*k +: 8]);
   endfunction

   function automatic logic [7:0] pick_delim();
      case ($urandom_range(0, 4))
         0: return CH_GT;
         1: return CH_SPACE;
         2: return CH_TAB;
         3: return CH_LF;
         default: return CH_SLASH;
      endcase
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0: return 8'($urandom_range(0, 255));
         1: return CH_LT;
         2: return CH_SLASH;
         3: return CH_GT;
         4: return name_byte($urandom_range(0, NAME_LIMIT - 1));
         default: return pick_delim();
      endcase
   endfunction

   function automatic logic [63:0] lower_name();
      logic [63:0] r;
      int k;
      for (k = 0; k < NAME_LIMIT; k++) r[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 25));
      return r;
   endfunction

   function automatic void push_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
   endfunction

   // Mostly well-formed documents with random content; the rest are cut short,
   // lack the closing tag, or are pure noise.
   function automatic void build_doc();
      int nl;
      int style;
      int part;
      int k;
      nl = sb.name_len();
      style = $urandom_range(0, 9);
      doc_bytes.delete();
      if (style == 9) begin
         repeat ($urandom_range(1, 10)) doc_bytes.push_back(noise_byte());
         return;
      end
      repeat ($urandom_range(0, 3)) doc_bytes.push_back(noise_byte());
      doc_bytes.push_back(CH_LT);
      for (k = 0; k < nl; k++) doc_bytes.push_back(name_byte(k));
      doc_bytes.push_back(pick_delim());
      if (doc_bytes[$] != CH_GT) begin
         repeat ($urandom_range(0, 3)) doc_bytes.push_back(noise_byte());
         doc_bytes.push_back(CH_GT);
      end
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(0, 3))
            0, 1: doc_bytes.push_back(noise_byte());
            2: begin
               doc_bytes.push_back(CH_LT);
               doc_bytes.push_back(CH_SLASH);
               part = $urandom_range(0, nl);
               for (k = 0; k < part; k++) doc_bytes.push_back(name_byte(k));
            end
            default: doc_bytes.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      if (style != 8) begin
         doc_bytes.push_back(CH_LT);
         doc_bytes.push_back(CH_SLASH);
         for (k = 0; k < nl; k++) doc_bytes.push_back(name_byte(k));
         doc_bytes.push_back(pick_delim());
      end
      repeat ($urandom_range(0, 3)) doc_bytes.push_back(noise_byte());
      if (style == 7) begin
         part = $urandom_range(1, doc_bytes.size());
         while (doc_bytes.size() > part) void'(doc_bytes.pop_back());
      end
   endfunction

   task automatic send_item(logic [7:0] b, logic last);
      req_type item;
      int gap;
      item.doc_byte = b;
      item.doc_end = last;
      if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
   endtask

   task automatic send_doc();
      int i;
      for (i = 0; i < doc_bytes.size(); i++) send_item(doc_bytes[i], i == doc_bytes.size() - 1);
   endtask

   task automatic random_docs();
      int sent;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         build_doc();
         send_doc();
         sent += doc_bytes.size();
      end
      req_valid <= 1'b0;
   endtask

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.configure(idx, value);
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(logic [3:0] len, logic [63:0] chars);
      wait_drained();
      write_register(CSR_TAG_LENGTH, {60'd0, len});
      write_register(CSR_TAG_CHARS, chars);
      csr_valid <= 1'b0;
      random_docs();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      doc_bytes.delete();
      push_text("<Article>");
      doc_bytes.push_back(8'h00);
      doc_bytes.push_back(8'hFF);
      push_text("</ARTICLE>");
      send_doc();
      doc_bytes.delete();
      doc_bytes.push_back(CH_LT);
      send_doc();
      random_docs();

      run_phase(4'd1, (lower_name() << 8) | 64'h70);
      run_phase(4'd8, lower_name());
      run_phase(4'd0, {$urandom, $urandom});
      run_phase(4'd15, lower_name());
      run_phase(4'd3, {40'd0, 8'h79, CH_GT, 8'h78});
      run_phase(4'($urandom_range(2, 7)), {$urandom, $urandom});
      run_phase(4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
      run_phase(4'd2, 64'h0);

      wait_drained();
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      int gap;
      bit calm;
      bit held_off;
      calm = 1'b0;
      held_off = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 15) == 0) calm = !calm;
         gap = calm ? 0 : $urandom_range(0, 9);
         // One long hold-off while requests keep coming fills the block up.
         if (!held_off && sb.requests_seen >= HOLD_AFTER) begin
            gap = LONG_HOLD;
            held_off = 1'b1;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
      end
   end

endmodule
